// ===== rtl/cau_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the centroid attraction update block.
// Used by the serial divider and the top level.
package cau_pkg;

	// Field widths
	localparam int COORD_W = 32;
	localparam int SUM_W   = 40;
	localparam int IDX_W   = 7;
	localparam int ALPHA_W = 16;
	localparam int POP_W   = 9;
	localparam int DIMC_W  = 8;
	localparam int CFG_W   = 16;

	// Parameter defaults
	localparam int DIM_MAX_DEF = 128;
	localparam int POP_MAX_DEF = 256;

	// Register reset values
	localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd6554;
	localparam logic [POP_W-1:0]   POP_RST   = 9'd1;
	localparam logic [DIMC_W-1:0]  DIMC_RST  = 8'd1;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_ALPHA = 2'd0,
		CFG_POP   = 2'd1,
		CFG_DIMC  = 2'd2,
		CFG_NONE  = 2'd3
	} cfg_idx_t;

	// Operation codes of an input item
	typedef enum logic [1:0] {
		MODE_BOUNDS = 2'd0,
		MODE_ACCUM  = 2'd1,
		MODE_UPDATE = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_INSIDE = 2'd0,
		ST_LOWER  = 2'd1,
		ST_UPPER  = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_DIV,
		S_DIFF,
		S_MUL,
		S_ADD,
		S_EMIT
	} cau_state_t;

	typedef struct packed {
		mode_t                     mode;
		logic [IDX_W-1:0]          dim_index;
		logic signed [COORD_W-1:0] coord_value;
		logic                      first_individual;
		logic signed [COORD_W-1:0] lower_limit;
		logic signed [COORD_W-1:0] upper_limit;
	} cau_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] new_value;
		logic [IDX_W-1:0]          out_dim_index;
		status_t                   status;
	} cau_result_t;

endpackage

// ===== rtl/cau_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload item per handshake.
// Payload type is given at instantiation.
interface cau_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/cau_div.sv =====
`timescale 1ns / 1ps
// Serial signed divider: restoring division, one quotient bit per cycle.
// Quotient truncates toward zero; depends on cau_pkg for default widths.
module cau_div
	import cau_pkg::*;
#(
	parameter int NW = SUM_W,
	parameter int DW = POP_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] dividend,
	input  logic [DW-1:0]        divisor,
	output logic                 busy,
	output logic                 done,
	output logic signed [NW-1:0] quotient
);
	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             neg_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    div_q;
	logic [DW:0]      trial;
	logic             fits;

	// Shift the next dividend bit into the partial remainder and test it
	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, div_q};

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Load magnitude, then advance one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[NW-1];
			quo_q <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? DW'(trial - {1'b0, div_q}) : trial[DW-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

// ===== rtl/centroid_attraction_update_top.sv =====
`timescale 1ns / 1ps
// Centroid attraction update: sequencer, dimension tables and output register.
// Depends on cau_pkg, cau_chan_if and cau_div.
//
// Each item is handled alone by a small sequencer around one serial divider and
// one multiplier. A bounds write steps through accept and decode, where the table is
// written; an accumulate through accept, decode and a table read and write; a flagged
// item through accept, decode and emit, and an ignored one through accept and decode.
// A coordinate update runs the divider that forms the centre (sum over population
// count), which produces one quotient bit per cycle over the 40-bit sum, followed by
// difference, multiply, add and clamp steps. A finished result sits in an output
// register, so the next item is taken while it waits. Tables hold no reset value;
// every entry must be written before it is read.
module centroid_attraction_update_top
	import cau_pkg::*;
#(
	parameter int DIM_MAX = DIM_MAX_DEF,
	parameter int POP_MAX = POP_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	cau_chan_if.sink           item_ch,
	cau_chan_if.source         result_ch,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);
	localparam int AW    = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
	localparam int PCL   = $clog2(POP_MAX + 1);
	localparam int CW    = (PCL < POP_W) ? PCL : POP_W;
	localparam int DIF_W = SUM_W + 1;
	localparam int PRD_W = DIF_W + ALPHA_W + 1;
	localparam int STP_W = PRD_W - ALPHA_W;
	localparam int NV_W  = STP_W + 1;

	// Configuration registers
	logic [ALPHA_W-1:0] alpha_q;
	logic [POP_W-1:0]   pop_q;
	logic [DIMC_W-1:0]  dimc_q;

	// Sequencer
	cau_state_t state_q, state_d;
	logic       lim_we, sum_we, div_start, out_load, err_set;

	// Item and datapath registers
	cau_item_t                 item_q;
	logic                      err_q;
	logic signed [SUM_W-1:0]   sum_rd_q;
	logic signed [COORD_W-1:0] lo_rd_q, up_rd_q;
	logic signed [SUM_W-1:0]   centre_q;
	logic signed [DIF_W-1:0]   diff_q;
	logic signed [PRD_W-1:0]   prod_q;
	logic signed [NV_W-1:0]    nv_q;

	// Output register
	logic        out_valid_q;
	cau_result_t out_q, res_d;

	// Tables
	logic signed [SUM_W-1:0]   sum_mem [DIM_MAX];
	logic signed [COORD_W-1:0] lo_mem  [DIM_MAX];
	logic signed [COORD_W-1:0] up_mem  [DIM_MAX];

	logic [AW-1:0]           addr;
	logic                    idx_ok;
	logic signed [SUM_W-1:0] coord_ext;
	logic signed [SUM_W-1:0] sum_wr;
	logic [CW-1:0]           count_eff;
	logic                    div_busy, div_done;
	logic signed [SUM_W-1:0] div_quo;
	logic                    out_free;
	logic signed [NV_W-1:0]  lo_ext, up_ext;

	assign addr      = AW'(item_q.dim_index);
	assign idx_ok    = ({1'b0, item_q.dim_index} < dimc_q)
		&& (32'(item_q.dim_index) < 32'(DIM_MAX));
	assign coord_ext = SUM_W'(item_q.coord_value);
	assign sum_wr    = item_q.first_individual ? coord_ext : sum_rd_q + coord_ext;
	assign out_free  = !out_valid_q || result_ch.ready;

	// Clamp the population count into its legal range
	always_comb begin
		priority if (pop_q == '0)
			count_eff = CW'(1);
		else if (32'(pop_q) > 32'(POP_MAX))
			count_eff = CW'(POP_MAX);
		else
			count_eff = CW'(pop_q);
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			pop_q   <= POP_RST;
			dimc_q  <= DIMC_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ALPHA: alpha_q <= cfg_data[ALPHA_W-1:0];
				CFG_POP:   pop_q   <= cfg_data[POP_W-1:0];
				CFG_DIMC:  dimc_q  <= cfg_data[DIMC_W-1:0];
				default: ;
			endcase
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and step controls
	always_comb begin
		state_d   = state_q;
		lim_we    = 1'b0;
		sum_we    = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		err_set   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (item_ch.valid)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				priority if (item_q.mode == MODE_NONE) begin
					state_d = S_IDLE;
				end else if (!idx_ok) begin
					err_set = 1'b1;
					state_d = S_EMIT;
				end else if (item_q.mode == MODE_BOUNDS) begin
					lim_we  = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				if (item_q.mode == MODE_ACCUM) begin
					sum_we  = 1'b1;
					state_d = S_IDLE;
				end else begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done)
					state_d = S_DIFF;
			end
			S_DIFF:  state_d = S_MUL;
			S_MUL:   state_d = S_ADD;
			S_ADD:   state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign item_ch.ready = (state_q == S_IDLE);

	// Capture the item and the error flag
	always_ff @(posedge clk) begin
		if (item_ch.valid && item_ch.ready) begin
			item_q <= item_ch.payload;
			err_q  <= 1'b0;
		end else if (err_set) begin
			err_q <= 1'b1;
		end
	end

	// Table writes and registered reads
	always_ff @(posedge clk) begin
		if (lim_we) begin
			lo_mem[addr] <= item_q.lower_limit;
			up_mem[addr] <= item_q.upper_limit;
		end
		if (sum_we)
			sum_mem[addr] <= sum_wr;
		sum_rd_q <= sum_mem[addr];
		lo_rd_q  <= lo_mem[addr];
		up_rd_q  <= up_mem[addr];
	end

	cau_div #(
		.NW(SUM_W),
		.DW(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_rd_q),
		.divisor  (count_eff),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Centre, difference, scaled step and moved coordinate, one step per cycle
	always_ff @(posedge clk) begin
		if (div_done)
			centre_q <= div_quo;
		if (state_q == S_DIFF)
			diff_q <= DIF_W'(centre_q) - DIF_W'(item_q.coord_value);
		if (state_q == S_MUL)
			prod_q <= diff_q * $signed({1'b0, alpha_q});
		if (state_q == S_ADD)
			nv_q <= NV_W'(item_q.coord_value) + NV_W'($signed(prod_q[PRD_W-1:ALPHA_W]));
	end

	// Clamp: lower test first, then upper
	assign lo_ext = NV_W'(lo_rd_q);
	assign up_ext = NV_W'(up_rd_q);

	always_comb begin
		res_d.out_dim_index = item_q.dim_index;
		priority if (err_q) begin
			res_d.new_value = '0;
			res_d.status    = ST_RANGE;
		end else if (nv_q < lo_ext) begin
			res_d.new_value = lo_rd_q;
			res_d.status    = ST_LOWER;
		end else if (nv_q > up_ext) begin
			res_d.new_value = up_rd_q;
			res_d.status    = ST_UPPER;
		end else begin
			res_d.new_value = nv_q[COORD_W-1:0];
			res_d.status    = ST_INSIDE;
		end
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (result_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load)
			out_q <= res_d;
	end

	assign result_ch.valid   = out_valid_q;
	assign result_ch.payload = out_q;

`ifndef NO_ASSERTIONS
	// The divider is started only when it is free
	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// A quotient arrives only while the sequencer waits for it
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide step");

	// A flagged index always returns a zero coordinate
	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.status != ST_RANGE || out_q.new_value == '0))
		else $error("out-of-range result carries a nonzero coordinate");

	// A result is loaded only into a free output register
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || result_ch.ready))
		else $error("pending result overwritten");
`endif
endmodule
